// ===== sv/tga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tga_pkg;
  localparam int PaletteDepth = 256;
  localparam int PalAw = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_MAP    = 3'd2,
    PH_PACKET = 3'd3,
    PH_PIXEL  = 3'd4,
    PH_IDLE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_BAD_PIX  = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_BAD_MAP  = 2'd3
  } kind_e;

  // front-to-back command: a run with its pixel still unresolved
  typedef struct packed {
    kind_e       kind;
    logic        mapped;
    logic [7:0]  index;
    logic [31:0] pixel;
    logic [2:0]  pixel_bytes;
    logic [7:0]  run_count;
    logic [15:0] column;
    logic [15:0] dest_row;
    logic        image_done;
  } cmd_t;

  // result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel;
    logic [2:0]  pixel_bytes;
    logic [7:0]  run_count;
    logic [15:0] column;
    logic [15:0] dest_row;
    logic        image_done;
  } res_t;

  // palette write from the parser
  typedef struct packed {
    logic             en;
    logic [PalAw-1:0] addr;
    logic [31:0]      data;
  } pal_wr_t;

  function automatic logic [31:0] swap02(input logic [31:0] v);
    swap02 = {v[31:24], v[7:0], v[15:8], v[23:16]};
  endfunction

  function automatic logic size_ok(input logic [7:0] b);
    size_ok = (b == 8'd8) || (b == 8'd24) || (b == 8'd32);
  endfunction
endpackage
`default_nettype wire

// ===== sv/tga_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tga_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  parameter int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/tga_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tga_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           first_i,
  output tga_pkg::cmd_t       cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output tga_pkg::pal_wr_t    pal_wr_o
);
  tga_pkg::phase_e phase_q, phase_d, ph;
  logic [4:0]  hidx_q, hidx_d;
  logic [7:0]  ident_q, ident_d, kind_q, kind_d, mbits_q, mbits_d, pbits_q, pbits_d;
  logic [15:0] ment_q, ment_d, width_q, width_d, height_q, height_d;
  logic [17:0] skip_q, skip_d;
  logic [7:0]  pleft_q, pleft_d;
  logic        prun_q, prun_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bip_q, bip_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [16:0] mpos_q, mpos_d;
  // remaining pixels, kept as a running count (height*width fits 32 bits)
  logic [31:0] rem_q, rem_d;
  // registered width*height, settled well before the last header byte
  logic [31:0] area_q;

  logic take, mapped, rle, wrap_busy, after_id, start_px;
  logic [31:0] acc_n;
  logic [2:0]  need, pb, eb;
  logic [31:0] n32;
  logic [16:0] sum;
  logic        done;

  // narrow images: column still past the row end, wrap one row per cycle
  assign wrap_busy = (col_q >= width_q) && (width_q != 16'd0) &&
                     (phase_q == tga_pkg::PH_PIXEL || phase_q == tga_pkg::PH_PACKET);
  assign in_ready_o = cmd_ready_i && !wrap_busy;
  assign take = in_valid_i && in_ready_o;
  assign ph = first_i ? tga_pkg::PH_HEADER : phase_q;
  assign mapped = (kind_q == 8'd1) || (kind_q == 8'd9);
  assign rle = (kind_q == 8'd9) || (kind_q == 8'd10);
  assign eb = mbits_q[5:3];
  assign need = mapped ? 3'd1 : pbits_q[5:3];
  assign pb = mapped ? mbits_q[5:3] : pbits_q[5:3];
  assign acc_n = acc_q | ({24'd0, data_byte_i} << {bip_q, 3'b000});

  always_ff @(posedge clk_i) area_q <= width_q * height_q;

  always_comb begin
    phase_d = phase_q; hidx_d = (take && first_i) ? 5'd0 : hidx_q;
    ident_d = ident_q; kind_d = kind_q; mbits_d = mbits_q; pbits_d = pbits_q;
    ment_d = ment_q; width_d = width_q; height_d = height_q; skip_d = skip_q;
    pleft_d = pleft_q; prun_d = prun_q; acc_d = acc_q; bip_d = bip_q;
    col_d = col_q; row_d = row_q; mpos_d = mpos_q; rem_d = rem_q;
    cmd_o = '0; cmd_valid_o = 1'b0; pal_wr_o = '0;
    n32 = 32'd1; sum = '0; done = 1'b0;
    after_id = 1'b0; start_px = 1'b0;
    if (take) begin
      case (ph)
        tga_pkg::PH_HEADER: begin
          case (hidx_d)
            5'd0:  ident_d = data_byte_i;
            5'd2:  kind_d = data_byte_i;
            5'd5:  ment_d[7:0] = data_byte_i;
            5'd6:  ment_d[15:8] = data_byte_i;
            5'd7:  mbits_d = data_byte_i;
            5'd12: width_d[7:0] = data_byte_i;
            5'd13: width_d[15:8] = data_byte_i;
            5'd14: height_d[7:0] = data_byte_i;
            5'd15: height_d[15:8] = data_byte_i;
            5'd16: pbits_d = data_byte_i;
            default: ;
          endcase
          if (hidx_d < 5'd17) begin
            hidx_d = hidx_d + 5'd1; phase_d = tga_pkg::PH_HEADER;
          end else begin
            hidx_d = '0;
            cmd_o.image_done = 1'b1;
            if (!tga_pkg::size_ok(pbits_q)) cmd_o.kind = tga_pkg::KIND_BAD_PIX;
            else if (!(kind_q == 8'd1 || kind_q == 8'd2 || kind_q == 8'd9 || kind_q == 8'd10))
              cmd_o.kind = tga_pkg::KIND_BAD_TYPE;
            else if (mapped && !tga_pkg::size_ok(mbits_q)) cmd_o.kind = tga_pkg::KIND_BAD_MAP;
            if (cmd_o.kind != tga_pkg::KIND_RUN) begin
              cmd_valid_o = 1'b1; phase_d = tga_pkg::PH_IDLE;
            end else if (ident_q != 8'd0) begin
              phase_d = tga_pkg::PH_SKIP;
              skip_d = {10'd0, ident_q};
            end else begin
              cmd_o.image_done = 1'b0;
              after_id = 1'b1;
            end
          end
        end
        tga_pkg::PH_SKIP: begin
          skip_d = skip_q - 18'd1;
          if (skip_d == 18'd0) after_id = 1'b1;
        end
        tga_pkg::PH_MAP: begin
          acc_d = acc_n; bip_d = bip_q + 2'd1;
          if ({1'b0, bip_q} + 3'd1 >= eb) begin
            pal_wr_o.en = (mpos_q < 17'(tga_pkg::PaletteDepth));
            pal_wr_o.addr = mpos_q[tga_pkg::PalAw-1:0];
            pal_wr_o.data = (eb >= 3'd3) ? tga_pkg::swap02(acc_n) : acc_n;
            mpos_d = mpos_q + 17'd1; bip_d = '0; acc_d = '0;
          end
          skip_d = skip_q - 18'd1;
          if (skip_d == 18'd0) start_px = 1'b1;
        end
        tga_pkg::PH_PACKET: begin
          prun_d = data_byte_i[7];
          pleft_d = {1'b0, data_byte_i[6:0]} + 8'd1;
          bip_d = '0; acc_d = '0; phase_d = tga_pkg::PH_PIXEL;
        end
        tga_pkg::PH_PIXEL: begin
          acc_d = acc_n; bip_d = bip_q + 2'd1;
          if ({1'b0, bip_q} + 3'd1 >= need) begin
            bip_d = '0; acc_d = '0;
            n32 = (rle && prun_q) ? {24'd0, pleft_q} : 32'd1;
            if (n32 > rem_q) n32 = rem_q;
            done = (n32 == rem_q);
            rem_d = rem_q - n32;
            cmd_valid_o = 1'b1;
            cmd_o.kind = tga_pkg::KIND_RUN;
            cmd_o.mapped = mapped;
            cmd_o.index = acc_n[7:0];
            cmd_o.pixel = (pb >= 3'd3) ? tga_pkg::swap02(acc_n) : acc_n;
            cmd_o.pixel_bytes = pb;
            cmd_o.run_count = n32[7:0];
            cmd_o.column = col_q;
            cmd_o.dest_row = height_q - 16'd1 - row_q;
            cmd_o.image_done = done;
            // one wrap here; width under 128 may need more, done while stalled
            sum = {1'b0, col_q} + {9'd0, n32[7:0]};
            if (sum >= {1'b0, width_q}) begin
              col_d = 16'(sum - {1'b0, width_q}); row_d = row_q + 16'd1;
            end else col_d = sum[15:0];
            if (rle) begin
              if (prun_q || pleft_q <= 8'd1) phase_d = tga_pkg::PH_PACKET;
              else pleft_d = pleft_q - 8'd1;
            end
            if (done) phase_d = tga_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    // narrow-width wrap: subtract width once per cycle, input paused
    if (wrap_busy) begin
      col_d = col_q - width_q; row_d = row_q + 16'd1;
    end
    // leaving header/skip: map load if mapped with map entries, else pixel data
    if (after_id) begin
      if (mapped && ment_q != 16'd0) begin
        skip_d = {2'd0, ment_q} * {15'd0, eb};
        mpos_d = '0; bip_d = '0; acc_d = '0; phase_d = tga_pkg::PH_MAP;
      end else begin
        start_px = 1'b1;
      end
    end
    if (start_px) begin
      bip_d = '0; acc_d = '0; col_d = '0; row_d = '0; rem_d = area_q;
      if (width_q == 16'd0 || height_q == 16'd0) phase_d = tga_pkg::PH_IDLE;
      else phase_d = rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tga_pkg::PH_HEADER; hidx_q <= '0; ident_q <= '0; kind_q <= '0;
      mbits_q <= '0; pbits_q <= '0; ment_q <= '0; width_q <= '0; height_q <= '0;
      skip_q <= '0; pleft_q <= '0; prun_q <= 1'b0; acc_q <= '0; bip_q <= '0;
      col_q <= '0; row_q <= '0; mpos_q <= '0; rem_q <= '0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; ident_q <= ident_d; kind_q <= kind_d;
      mbits_q <= mbits_d; pbits_q <= pbits_d; ment_q <= ment_d; width_q <= width_d;
      height_q <= height_d; skip_q <= skip_d; pleft_q <= pleft_d; prun_q <= prun_d;
      acc_q <= acc_d; bip_q <= bip_d; col_q <= col_d; row_q <= row_d;
      mpos_q <= mpos_d; rem_q <= rem_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tga_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tga_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tga_pkg::cmd_t cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire tga_pkg::pal_wr_t pal_wr_i,
  output tga_pkg::res_t    res_o,
  output logic             res_valid_o,
  input  wire logic        res_ready_i
);
  // stage 1: palette read in flight; stage 2: output register
  logic          s1_v_q, s2_v_q;
  tga_pkg::cmd_t s1_q;
  tga_pkg::res_t s2_q;
  logic [31:0]   rdata, px;
  logic          adv2, adv1;

  tga_ram #(.Width(32), .Depth(tga_pkg::PaletteDepth)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_wr_i.en),
    .waddr_i (pal_wr_i.addr),
    .wdata_i (pal_wr_i.data),
    .re_i    (adv1),
    .raddr_i (cmd_i.index[tga_pkg::PalAw-1:0]),
    .rdata_o (rdata)
  );

  assign adv2 = !s2_v_q || res_ready_i;
  assign adv1 = !s1_v_q || adv2;
  assign cmd_ready_o = adv1;

  always_comb begin
    px = s1_q.mapped ?
         ((s1_q.index < 8'(tga_pkg::PaletteDepth - 1) + 8'd1 ||
           tga_pkg::PaletteDepth == 256) ? rdata : 32'd0) : s1_q.pixel;
    if (s1_q.pixel_bytes == 3'd1) px = {24'd0, px[7:0]};
    else if (s1_q.pixel_bytes == 3'd3) px = {8'd0, px[23:0]};
    if (s1_q.kind != tga_pkg::KIND_RUN) px = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= cmd_i;
    if (adv2 && s1_v_q) s2_q <= {s1_q.kind, px, s1_q.pixel_bytes, s1_q.run_count,
                                 s1_q.column, s1_q.dest_row, s1_q.image_done};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= cmd_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
    end
  end

  assign res_o = s2_q;
  assign res_valid_o = s2_v_q;
endmodule
`default_nettype wire

// ===== sv/tga_image_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// tga image stream decoder
// slave channel: one file byte per item, tdata = data_byte, tuser = first
// (first restarts the header parser on that byte)
// master channel: one pixel run or error per item, tuser = kind,
// tlast = image_done, other fields in tdata below
// the front parser takes one byte per cycle unless stalled; the back end
// resolves the palette lookup through a registered ram read, then an
// output register
// throughput: one byte per cycle while the master side accepts; narrow
// images (width under 128) may pause input for each extra row wrap of an rle run
// reset clears all control state and returns the parser to the header;
// the palette ram is not cleared and only entries written by the map load
// are defined
// when the master side stalls the two back stages hold and tready on the
// slave side falls until space frees up
module tga_image_stream_decoder_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // data_byte
  input  wire logic         s_axis_tuser,  // first
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // chan0 chan1 chan2 chan3 pixel_bytes[3] run_count[8] column[16]
  // dest_row[16], padded to 80 bits
  output logic [79:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,  // kind
  output logic              m_axis_tlast   // image_done
);
  tga_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_ready;
  tga_pkg::pal_wr_t pal_wr;
  tga_pkg::res_t    res;

  tga_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .first_i     (s_axis_tuser),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .pal_wr_o    (pal_wr)
  );

  tga_back u_back (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .pal_wr_i    (pal_wr),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res.dest_row, res.column, res.run_count,
                         res.pixel_bytes, res.pixel[31:24], res.pixel[23:16],
                         res.pixel[15:8], res.pixel[7:0]};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.image_done;

  // error results always close the image
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.kind != tga_pkg::KIND_RUN |-> res.image_done)
    else $error("error result without image_done");
  // a pixel run never has zero length
  a_run_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.kind == tga_pkg::KIND_RUN |-> res.run_count != 8'd0)
    else $error("empty run");
endmodule
`default_nettype wire
